/* hdl/radar_report_frame_parser_defines.svh */
// Assertion macros for the radar report frame parser.
// Included by the top level; needs a clock named clock and a reset named reset.
`ifndef RADAR_REPORT_FRAME_PARSER_DEFINES_SVH
`define RADAR_REPORT_FRAME_PARSER_DEFINES_SVH

// Concurrent check sampled on the rising clock edge, off while reset is high.
`define RRFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that holds only while a result item is offered.
`define RRFP_ASSERT_RSP(label, prop, msg) \
   `RRFP_ASSERT(label, (rsp_valid |-> (prop)), msg)

`endif

/* hdl/rrfp_pkg.sv */
// Shared types and constants of the radar report frame parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rrfp_pkg;

   // Frame layout: header bytes 0..3, body bytes 4..22.
   localparam int HDR_LEN    = 4;
   localparam int FRAME_LEN  = 23;
   localparam int BODY_LEN   = FRAME_LEN - HDR_LEN;
   localparam int POS_W      = 5;
   localparam int QUEUE_DEPTH = 2;

   // Byte positions inside the frame.
   localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd4;
   localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd5;
   localparam logic [POS_W-1:0] POS_TYPE     = 5'd6;
   localparam logic [POS_W-1:0] POS_HEAD     = 5'd7;
   localparam logic [POS_W-1:0] POS_STATE    = 5'd8;
   localparam logic [POS_W-1:0] POS_MDIST_LO = 5'd9;
   localparam logic [POS_W-1:0] POS_MDIST_HI = 5'd10;
   localparam logic [POS_W-1:0] POS_MENERGY  = 5'd11;
   localparam logic [POS_W-1:0] POS_SDIST_LO = 5'd12;
   localparam logic [POS_W-1:0] POS_SDIST_HI = 5'd13;
   localparam logic [POS_W-1:0] POS_SENERGY  = 5'd14;
   localparam logic [POS_W-1:0] POS_TMARK    = 5'd17;
   localparam logic [POS_W-1:0] POS_TAIL0    = 5'd19;
   localparam logic [POS_W-1:0] POS_TAIL1    = 5'd20;
   localparam logic [POS_W-1:0] POS_TAIL2    = 5'd21;
   localparam logic [POS_W-1:0] POS_TAIL3    = 5'd22;
   localparam logic [POS_W-1:0] POS_LAST     = POS_TAIL3;

   // Expected byte values.
   localparam logic [7:0] HDR_BYTE0    = 8'hF4;
   localparam logic [7:0] HDR_BYTE1    = 8'hF3;
   localparam logic [7:0] HDR_BYTE2    = 8'hF2;
   localparam logic [7:0] HDR_BYTE3    = 8'hF1;
   localparam logic [7:0] TAIL_BYTE0   = 8'hF8;
   localparam logic [7:0] TAIL_BYTE1   = 8'hF7;
   localparam logic [7:0] TAIL_BYTE2   = 8'hF6;
   localparam logic [7:0] TAIL_BYTE3   = 8'hF5;
   localparam logic [7:0] LEN_EXPECTED = 8'd13;
   localparam logic [7:0] TYPE_REPORT  = 8'h02;
   localparam logic [7:0] HEAD_MARK    = 8'hAA;
   localparam logic [7:0] TAIL_MARK    = 8'h55;
   localparam logic [7:0] STATE_MAX    = 8'd3;
   localparam logic [7:0] ENERGY_MAX   = 8'd100;

   // Fault flag bit positions, in priority order: the lowest set bit gives the status.
   localparam int FLAG_TAIL   = 0;
   localparam int FLAG_LEN    = 1;
   localparam int FLAG_TYPE   = 2;
   localparam int FLAG_HEAD   = 3;
   localparam int FLAG_TMARK  = 4;
   localparam int FLAG_STATE  = 5;
   localparam int FLAG_ENERGY = 6;
   localparam int FLAG_COUNT  = 7;

   typedef enum logic [2:0] {
      STATUS_OK     = 3'd0,
      STATUS_TAIL   = 3'd1,
      STATUS_LEN    = 3'd2,
      STATUS_TYPE   = 3'd3,
      STATUS_HEAD   = 3'd4,
      STATUS_TMARK  = 3'd5,
      STATUS_STATE  = 3'd6,
      STATUS_ENERGY = 3'd7
   } status_type;

   // One body byte handed from the front to the back.
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [7:0]       data;
   } body_item_type;

   // Expected header byte for a given match count.
   function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = HDR_BYTE0;
         2'd1:    b = HDR_BYTE1;
         2'd2:    b = HDR_BYTE2;
         default: b = HDR_BYTE3;
      endcase
      return b;
   endfunction

   // Status code of the lowest-numbered set flag; ok when no flag is set.
   function automatic status_type status_of(input logic [FLAG_COUNT-1:0] flags);
      status_type st;
      st = STATUS_OK;
      for (int i = FLAG_COUNT - 1; i >= 0; i--) begin
         if (flags[3'(i)]) begin
            st = status_type'(3'(i + 1));
         end
      end
      return st;
   endfunction

endpackage

/* hdl/rrfp_front.sv */
// Front end of the radar report frame parser: header hunt and body tagging.
// Depends on rrfp_pkg.
`timescale 1ns / 1ps

module rrfp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output logic                   push_valid,
   input  logic                   push_ready,
   output rrfp_pkg::body_item_type push_item
);

   localparam logic [4:0] LAST_COUNT = 5'(rrfp_pkg::BODY_LEN - 1);

   logic [1:0] header_matched_ff, header_matched_in;
   logic       in_body_ff, in_body_in;
   logic [4:0] body_count_ff, body_count_in;
   logic       accept;

   // Bytes are taken whenever the queue has room; header bytes just drop there.
   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && in_body_ff;
   assign push_item.pos  = body_count_ff + 5'(rrfp_pkg::HDR_LEN);
   assign push_item.data = req_rx_byte;

   // Header matching and body counting.
   always_comb begin
      header_matched_in = header_matched_ff;
      in_body_in        = in_body_ff;
      body_count_in     = body_count_ff;
      if (accept) begin
         if (!in_body_ff) begin
            if (req_rx_byte == rrfp_pkg::hdr_byte(header_matched_ff)) begin
               if (header_matched_ff == 2'(rrfp_pkg::HDR_LEN - 1)) begin
                  header_matched_in = 2'd0;
                  in_body_in        = 1'b1;
                  body_count_in     = 5'd0;
               end else begin
                  header_matched_in = header_matched_ff + 2'd1;
               end
            end else if (req_rx_byte == rrfp_pkg::HDR_BYTE0) begin
               header_matched_in = 2'd1;
            end else begin
               header_matched_in = 2'd0;
            end
         end else if (body_count_ff == LAST_COUNT) begin
            in_body_in    = 1'b0;
            body_count_in = 5'd0;
         end else begin
            body_count_in = body_count_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_matched_ff <= 2'd0;
         in_body_ff        <= 1'b0;
         body_count_ff     <= 5'd0;
      end else begin
         header_matched_ff <= header_matched_in;
         in_body_ff        <= in_body_in;
         body_count_ff     <= body_count_in;
      end
   end

endmodule

/* hdl/rrfp_queue.sv */
// Small FIFO of tagged body bytes between front and back.
// Depends on rrfp_pkg.
`timescale 1ns / 1ps

module rrfp_queue #(
   parameter int DEPTH = rrfp_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  rrfp_pkg::body_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output rrfp_pkg::body_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rrfp_pkg::body_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer wrap and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/rrfp_back.sv */
// Back end of the radar report frame parser: field checks, capture, result register.
// Depends on rrfp_pkg.
`timescale 1ns / 1ps

module rrfp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  rrfp_pkg::body_item_type pop_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [1:0]              rsp_presence,
   output logic                    rsp_occupied,
   output logic [15:0]             rsp_moving_distance,
   output logic [6:0]              rsp_moving_strength,
   output logic [15:0]             rsp_static_distance,
   output logic [6:0]              rsp_static_strength
);

   logic [rrfp_pkg::FLAG_COUNT-1:0] fault_flags_ff, fault_flags_in;
   logic [1:0]  cap_state_ff, cap_state_in;
   logic [15:0] cap_mdist_ff, cap_mdist_in;
   logic [6:0]  cap_menergy_ff, cap_menergy_in;
   logic [15:0] cap_sdist_ff, cap_sdist_in;
   logic [6:0]  cap_senergy_ff, cap_senergy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff;
   logic [1:0]  state_ff;
   logic        occupied_ff;
   logic [15:0] mdist_ff, sdist_ff;
   logic [6:0]  menergy_ff, senergy_ff;
   logic        is_last, out_free, take, finish;
   logic [7:0]  b;
   rrfp_pkg::status_type status_in;

   assign b         = pop_item.data;
   assign is_last   = (pop_item.pos == rrfp_pkg::POS_LAST);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !is_last || out_free;
   assign take      = pop_valid && pop_ready;
   assign finish    = take && is_last;

   // Per-position checks and field capture.
   always_comb begin
      fault_flags_in = fault_flags_ff;
      cap_state_in   = cap_state_ff;
      cap_mdist_in   = cap_mdist_ff;
      cap_menergy_in = cap_menergy_ff;
      cap_sdist_in   = cap_sdist_ff;
      cap_senergy_in = cap_senergy_ff;
      if (take) begin
         case (pop_item.pos)
            rrfp_pkg::POS_LEN_LO: begin
               if (b != rrfp_pkg::LEN_EXPECTED) fault_flags_in[rrfp_pkg::FLAG_LEN] = 1'b1;
            end
            rrfp_pkg::POS_LEN_HI: begin
               if (b != 8'd0) fault_flags_in[rrfp_pkg::FLAG_LEN] = 1'b1;
            end
            rrfp_pkg::POS_TYPE: begin
               if (b != rrfp_pkg::TYPE_REPORT) fault_flags_in[rrfp_pkg::FLAG_TYPE] = 1'b1;
            end
            rrfp_pkg::POS_HEAD: begin
               if (b != rrfp_pkg::HEAD_MARK) fault_flags_in[rrfp_pkg::FLAG_HEAD] = 1'b1;
            end
            rrfp_pkg::POS_STATE: begin
               if (b > rrfp_pkg::STATE_MAX) fault_flags_in[rrfp_pkg::FLAG_STATE] = 1'b1;
               cap_state_in = b[1:0];
            end
            rrfp_pkg::POS_MDIST_LO: cap_mdist_in[7:0]  = b;
            rrfp_pkg::POS_MDIST_HI: cap_mdist_in[15:8] = b;
            rrfp_pkg::POS_MENERGY: begin
               if (b > rrfp_pkg::ENERGY_MAX) fault_flags_in[rrfp_pkg::FLAG_ENERGY] = 1'b1;
               cap_menergy_in = b[6:0];
            end
            rrfp_pkg::POS_SDIST_LO: cap_sdist_in[7:0]  = b;
            rrfp_pkg::POS_SDIST_HI: cap_sdist_in[15:8] = b;
            rrfp_pkg::POS_SENERGY: begin
               if (b > rrfp_pkg::ENERGY_MAX) fault_flags_in[rrfp_pkg::FLAG_ENERGY] = 1'b1;
               cap_senergy_in = b[6:0];
            end
            rrfp_pkg::POS_TMARK: begin
               if (b != rrfp_pkg::TAIL_MARK) fault_flags_in[rrfp_pkg::FLAG_TMARK] = 1'b1;
            end
            rrfp_pkg::POS_TAIL0: begin
               if (b != rrfp_pkg::TAIL_BYTE0) fault_flags_in[rrfp_pkg::FLAG_TAIL] = 1'b1;
            end
            rrfp_pkg::POS_TAIL1: begin
               if (b != rrfp_pkg::TAIL_BYTE1) fault_flags_in[rrfp_pkg::FLAG_TAIL] = 1'b1;
            end
            rrfp_pkg::POS_TAIL2: begin
               if (b != rrfp_pkg::TAIL_BYTE2) fault_flags_in[rrfp_pkg::FLAG_TAIL] = 1'b1;
            end
            rrfp_pkg::POS_TAIL3: begin
               if (b != rrfp_pkg::TAIL_BYTE3) fault_flags_in[rrfp_pkg::FLAG_TAIL] = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // The status includes the checks of the last byte itself.
   assign status_in = rrfp_pkg::status_of(fault_flags_in);

   // Output valid: set by a finished frame, cleared when the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_flags_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fault_flags_ff <= finish ? '0 : fault_flags_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Captured fields are always rewritten before they are reported.
   always_ff @(posedge clock) begin
      cap_state_ff   <= cap_state_in;
      cap_mdist_ff   <= cap_mdist_in;
      cap_menergy_ff <= cap_menergy_in;
      cap_sdist_ff   <= cap_sdist_in;
      cap_senergy_ff <= cap_senergy_in;
   end

   // Result register; every field but status is zero on a failed check.
   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff <= status_in;
         if (status_in == rrfp_pkg::STATUS_OK) begin
            state_ff    <= cap_state_in;
            occupied_ff <= (cap_state_in != 2'd0);
            mdist_ff    <= cap_mdist_in;
            menergy_ff  <= cap_menergy_in;
            sdist_ff    <= cap_sdist_in;
            senergy_ff  <= cap_senergy_in;
         end else begin
            state_ff    <= 2'd0;
            occupied_ff <= 1'b0;
            mdist_ff    <= 16'd0;
            menergy_ff  <= 7'd0;
            sdist_ff    <= 16'd0;
            senergy_ff  <= 7'd0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_presence        = state_ff;
   assign rsp_occupied        = occupied_ff;
   assign rsp_moving_distance = mdist_ff;
   assign rsp_moving_strength = menergy_ff;
   assign rsp_static_distance = sdist_ff;
   assign rsp_static_strength = senergy_ff;

endmodule

/* hdl/radar_report_frame_parser.sv */
// With an empty queue, the frame's last byte passes the queue entry register, then the back
// loads the result register. Throughput: one byte per cycle; the front accepts whenever the
// body queue has room. A stalled result holds the back at the last byte of the next frame.
// Reset (synchronous, active high) clears the header hunt, the queue and the result valid.
// Top level of the radar report frame parser; uses rrfp_pkg, rrfp_front,
// rrfp_queue, rrfp_back and radar_report_frame_parser_defines.svh.
`timescale 1ns / 1ps
`include "radar_report_frame_parser_defines.svh"

module radar_report_frame_parser #(
   parameter int QUEUE_DEPTH = rrfp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_presence,
   output logic        rsp_occupied,
   output logic [15:0] rsp_moving_distance,
   output logic [6:0]  rsp_moving_strength,
   output logic [15:0] rsp_static_distance,
   output logic [6:0]  rsp_static_strength
);

   logic                    push_valid, push_ready;
   logic                    pop_valid, pop_ready;
   rrfp_pkg::body_item_type push_item, pop_item;
   logic                    rsp_ok, rsp_fields_zero, strength_in_range;

   // Header hunt and body tagging.
   rrfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Body byte queue.
   rrfp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item (push_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item)
   );

   // Checks, capture and result register.
   rrfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_item           (pop_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_presence       (rsp_presence),
      .rsp_occupied       (rsp_occupied),
      .rsp_moving_distance(rsp_moving_distance),
      .rsp_moving_strength(rsp_moving_strength),
      .rsp_static_distance(rsp_static_distance),
      .rsp_static_strength(rsp_static_strength)
   );

   // Terms used by the checks below.
   assign rsp_ok            = (rsp_status == rrfp_pkg::STATUS_OK);
   assign rsp_fields_zero   = (rsp_presence == 2'd0) && !rsp_occupied &&
                              (rsp_moving_distance == 16'd0) &&
                              (rsp_static_distance == 16'd0) &&
                              (rsp_moving_strength == 7'd0) && (rsp_static_strength == 7'd0);
   assign strength_in_range = (rsp_moving_strength <= 7'(rrfp_pkg::ENERGY_MAX)) &&
                              (rsp_static_strength <= 7'(rrfp_pkg::ENERGY_MAX));

   // A failed check reports no field values.
   `RRFP_ASSERT_RSP(a_err_zero, rsp_ok || rsp_fields_zero, "fields set on a failed check")
   // The occupied flag follows the reported presence code.
   `RRFP_ASSERT_RSP(a_occupied, rsp_occupied == (rsp_presence != 2'd0), "flag disagrees")
   // A passing frame never reports an energy above the limit.
   `RRFP_ASSERT_RSP(a_energy_range, !rsp_ok || strength_in_range, "energy above the limit")
   // The front only hands over body bytes when the queue can take them.
   `RRFP_ASSERT(a_queue_room, (push_valid && !push_ready) |-> !req_ready, "queue overrun")

endmodule
